### hdl/scti_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scti_pkg: shared constants for the sine/cosine table interpolator
// Default sizes, angle conversion factors, mode bit positions and the
// Taylor series divisors used to build the sine table at elaboration.
// ----------------------------------------------------------------------------
package scti_pkg;

  // default configuration
  localparam int DEF_TABLE_LENGTH = 802;
  localparam int DEF_SAMPLE_BITS  = 16;

  // input word layout
  localparam int PHASE_W      = 24;
  localparam int MODE_W       = 2;
  localparam int MODE_COS_BIT = 0;  // 0 sine, 1 cosine
  localparam int MODE_RAD_BIT = 1;  // 0 turns Q0.24, 1 radians Q3.21

  // position arithmetic
  localparam int FRAC_W    = 16;  // fraction bits of a table position
  localparam int T32_W     = 33;  // turns in Q32, radians reach about 1.27 turns
  localparam int INV_W     = 30;  // width of the 1/(2 pi) factor
  localparam int RAD_SHIFT = 21;  // radians carry 21 fraction bits
  localparam int TURN_PAD  = 8;   // Q0.24 turns to Q32 turns

  localparam logic [INV_W-1:0] INV_TWO_PI_Q32 = INV_W'(683565276);

  // sine table construction (elaboration only)
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DEN [7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

endpackage
`default_nettype wire

### hdl/sine_cosine_table_interpolator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sine_cosine_table_interpolator_unit: table sine/cosine with interpolation
// Maps a phase in turns or radians to a position in a sine table, adds a
// quarter cycle for cosine, and interpolates linearly between two entries.
// ----------------------------------------------------------------------------
//
//   channel | signals                               | direction | word
//   --------+---------------------------------------+-----------+-------------------
//   in      | in_valid_i in_ready_o phase_i mode_i  | sink      | phase, mode
//   out     | out_valid_o out_ready_i sample_o      | source    | interpolated sample
//
// One word enters per cycle unless the output stalls or the table is loading.
// The six stages are: angle to Q32 turns, scale to a table position,
// quarter offset and wrap, table read, slope multiply, round and add.
// After reset the table memory is loaded from the constant image, one
// entry a cycle, until every entry is written; in_ready_o stays low meanwhile.
// A stalled output holds its word; each stage advances when the stage
// after it is empty or advancing, so bubbles close up under a stall.
//
module sine_cosine_table_interpolator_unit #(
  parameter int TABLE_LENGTH = scti_pkg::DEF_TABLE_LENGTH,
  parameter int SAMPLE_BITS  = scti_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [scti_pkg::PHASE_W-1:0]     phase_i,
  input  wire logic [scti_pkg::MODE_W-1:0]      mode_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]         sample_o
);

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int IDX_W  = $clog2(TABLE_LENGTH);       // table index
  localparam int TL_W   = $clog2(TABLE_LENGTH + 1);   // holds TABLE_LENGTH itself
  localparam int POS_W  = IDX_W + scti_pkg::FRAC_W + 1; // position, below 2 spans
  localparam int PMUL_W = scti_pkg::PHASE_W + scti_pkg::INV_W;
  localparam int SMUL_W = scti_pkg::T32_W + TL_W;
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = SAMPLE_BITS + scti_pkg::FRAC_W + 2;
  localparam int SUM_W  = SAMPLE_BITS + 2;

  localparam logic [POS_W-1:0] SPAN    = POS_W'(TABLE_LENGTH) << scti_pkg::FRAC_W;
  localparam logic [POS_W-1:0] QUARTER = POS_W'(TABLE_LENGTH) << (scti_pkg::FRAC_W - 2);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_LENGTH - 1);

  // --------------------------------------------------------------------------
  // Table image, built at elaboration: round(sin(2 pi i / L) * 2^(B-1)), with
  // the peak clamped to the largest sample, from a Q30 Taylor series on the quarter wave.
  // --------------------------------------------------------------------------
  typedef logic signed [SAMPLE_BITS-1:0] rom_t [TABLE_LENGTH];

  function automatic longint quarter_sin_q30(longint unsigned m);
    longint unsigned a;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    a    = (m * scti_pkg::HALF_PI_Q30) / TABLE_LENGTH;
    x2   = (a * a) >> 30;
    term = a;
    sum  = longint'(a);
    for (int k = 0; k < 7; k++) begin
      term = (term * x2) >> 30;
      term = term / scti_pkg::TAYLOR_DEN[k];
      if (k[0] == 1'b0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

  function automatic longint quarter_entry(longint unsigned m);
    longint s;
    longint mag;
    longint maxv;
    maxv = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    s    = quarter_sin_q30(m);
    if (s < 0) begin
      s = 0;
    end
    mag = (s + (64'sd1 <<< (30 - SAMPLE_BITS))) >>> (31 - SAMPLE_BITS);
    if (mag > maxv) begin
      mag = maxv;
    end
    return mag;
  endfunction

  function automatic rom_t build_rom();
    rom_t            img;
    longint unsigned n;
    longint unsigned q;
    longint unsigned r;
    longint          e;
    for (int i = 0; i < TABLE_LENGTH; i++) begin
      n = 64'(4 * i);
      q = n / TABLE_LENGTH;
      r = n % TABLE_LENGTH;
      unique case (q[1:0])
        2'd0:    e = quarter_entry(r);
        2'd1:    e = quarter_entry(64'(TABLE_LENGTH) - r);
        2'd2:    e = -quarter_entry(r);
        default: e = -quarter_entry(64'(TABLE_LENGTH) - r);
      endcase
      img[i] = SAMPLE_BITS'(e);
    end
    return img;
  endfunction

  localparam rom_t ROM_IMAGE = build_rom();

  // --------------------------------------------------------------------------
  // Table load after reset
  // --------------------------------------------------------------------------
  logic             fill_busy_q, fill_busy_d;
  logic [IDX_W-1:0] fill_q, fill_d;

  always_comb begin
    fill_busy_d = fill_busy_q;
    fill_d      = fill_q;
    if (fill_busy_q) begin
      if (fill_q == LAST_IDX) begin
        fill_busy_d = 1'b0;
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_busy_q <= 1'b1;
      fill_q      <= '0;
    end else begin
      fill_busy_q <= fill_busy_d;
      fill_q      <= fill_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage valid bits and advance enables
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;
  logic take;

  // a stage advances when the next one is empty or advancing
  assign en6  = !v6_q || out_ready_i;
  assign en5  = !v5_q || en6;
  assign en4  = !v4_q || en5;
  assign en3  = !v3_q || en4;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;

  assign in_ready_o = en1 && !fill_busy_q;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= take;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: angle to turns in Q32. Radians multiply by 1/(2 pi).
  // --------------------------------------------------------------------------
  logic [PMUL_W-1:0]             rad_prod;
  logic [scti_pkg::T32_W-1:0]    t32_d, t32_q;
  logic                          cos1_q;

  assign rad_prod = PMUL_W'(phase_i) * PMUL_W'(scti_pkg::INV_TWO_PI_Q32);

  always_comb begin
    if (mode_i[scti_pkg::MODE_RAD_BIT]) begin
      t32_d = rad_prod[scti_pkg::RAD_SHIFT +: scti_pkg::T32_W];
    end else begin
      t32_d = {1'b0, phase_i, {scti_pkg::TURN_PAD{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && take) begin
      t32_q  <= t32_d;
      cos1_q <= mode_i[scti_pkg::MODE_COS_BIT];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale turns to a table position with 16 fraction bits
  // --------------------------------------------------------------------------
  logic [SMUL_W-1:0] scale_prod;
  logic [POS_W-1:0]  pos2_q;
  logic              cos2_q;

  assign scale_prod = SMUL_W'(t32_q) * SMUL_W'(TABLE_LENGTH);

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      pos2_q <= scale_prod[scti_pkg::FRAC_W +: POS_W];
      cos2_q <= cos1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: quarter-cycle offset for cosine, wrap once, split the position
  // --------------------------------------------------------------------------
  logic [POS_W-1:0]            pos_off, pos_wrap;
  logic [IDX_W-1:0]            idx_d, nxt_d;
  logic [IDX_W-1:0]            idx3_q, nxt3_q;
  logic [scti_pkg::FRAC_W-1:0] frac3_q;

  always_comb begin
    pos_off = pos2_q + (cos2_q ? QUARTER : '0);
    // the position stays below two spans, so one subtract wraps it
    if (pos_off >= SPAN) begin
      pos_wrap = pos_off - SPAN;
    end else begin
      pos_wrap = pos_off;
    end
    idx_d = pos_wrap[scti_pkg::FRAC_W +: IDX_W];
    if (idx_d == LAST_IDX) begin
      nxt_d = '0;
    end else begin
      nxt_d = idx_d + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      idx3_q  <= idx_d;
      nxt3_q  <= nxt_d;
      frac3_q <= pos_wrap[scti_pkg::FRAC_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: read both neighbors from the table memory
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0]      ent_a, ent_b;
  logic [scti_pkg::FRAC_W-1:0] frac4_q;

  scti_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TABLE_LENGTH)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (fill_busy_q),
    .waddr_i   (fill_q),
    .wdata_i   (ROM_IMAGE[fill_q]),
    .re_i      (en4),
    .raddr_a_i (idx3_q),
    .raddr_b_i (nxt3_q),
    .rdata_a_o (ent_a),
    .rdata_b_o (ent_b)
  );

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      frac4_q <= frac3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: slope times fraction
  // --------------------------------------------------------------------------
  logic signed [DIFF_W-1:0]      diff;
  logic signed [scti_pkg::FRAC_W:0] frac_s;
  logic signed [PROD_W-1:0]      prod_d, prod5_q;
  logic signed [SAMPLE_BITS-1:0] a5_q;

  assign diff   = DIFF_W'($signed(ent_b)) - DIFF_W'($signed(ent_a));
  assign frac_s = $signed({1'b0, frac4_q});
  assign prod_d = PROD_W'(diff) * PROD_W'(frac_s);

  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      prod5_q <= prod_d;
      a5_q    <= $signed(ent_a);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: round to nearest (ties up) and add the base entry
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0]      prod_rnd;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  assign prod_rnd = prod5_q + PROD_W'(32768);
  assign sum      = SUM_W'(a5_q) + $signed(prod_rnd[PROD_W-1:scti_pkg::FRAC_W]);

  always_ff @(posedge clk_i) begin
    if (en6 && v5_q) begin
      sample_q <= sum[SAMPLE_BITS-1:0];
    end
  end

  assign out_valid_o = v6_q;
  assign sample_o    = sample_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // no word may be in flight while the table is still loading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_busy_q |-> !(v1_q || v2_q || v3_q || v4_q || v5_q || v6_q))
    else $error("word in pipeline during table load");

  // the index after wrap always lands inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (idx3_q <= LAST_IDX))
    else $error("table index out of range");

  // the neighbor entry follows the index and wraps to the start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> ((nxt3_q == IDX_W'(idx3_q + 1'b1)) ||
              ((idx3_q == LAST_IDX) && (nxt3_q == '0))))
    else $error("neighbor index mismatch");

  // a word taken at the input shows up in stage 1 on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted word lost at stage 1");

endmodule
`default_nettype wire

### hdl/scti_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scti_ram: generic memory, one write port, two registered read ports
// Both read ports share one read enable; read data holds while it is low.
// ----------------------------------------------------------------------------
module scti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 802
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule
`default_nettype wire
